// ===== design/bpls_pkg.sv =====
// Shared types and constants for the button press qualifier.
package bpls_pkg;

  localparam logic CMD_LEVEL = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [2:0] CFG_DEBOUNCE_TICKS  = 3'd0;
  localparam logic [2:0] CFG_LONG_PRESS_TICKS = 3'd1;
  localparam logic [2:0] CFG_PRESSED_LEVEL   = 3'd2;
  localparam logic [2:0] CFG_LONG_ENABLE     = 3'd3;
  localparam logic [2:0] CFG_SHIFTER_VALID   = 3'd4;
  localparam logic [2:0] CFG_SHIFTER_SELECT  = 3'd5;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [15:0] LONG_RESET     = 16'd1000;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_DEBOUNCE,
    MODE_LONG,
    MODE_HOLD
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SECOND,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [2:0] button;
    logic       pressed;
    logic       shifted;
    logic       long_flag;
  } event_t;

  typedef struct packed {
    logic load_pin;
    logic step_en;
    logic push_second;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] ev_cnt;
    logic       push_ok;
    logic       out_free;
    logic       hold_v;
  } dp_stat_t;

endpackage

// ===== design/button_press_longpress_shift.sv =====
// Top level of the button qualifier: debounce, long press and shift events for a small keypad.
//
//   port group  direction  word
//   in_*        input      command, button_index, level
//   out_*       output     event_button, pressed, shifted, long_flag, last
//   cfg_*       input      register index and write data, no read-back
//
// A level-change word is taken in ST_IDLE, which it does not leave. A tick word starts a scan
// that visits each button (NUM_BUTTONS, at most 8) in turn over the shared expire logic, with
// a ST_SECOND step per press-and-release pair, and ends in ST_FLUSH; out_stall can hold it.
// rst_n is synchronous; it clears all timers, levels and marks and loads register defaults.
// in_stall is high from the cycle after a tick is taken until ST_FLUSH is left; out_stall
// holds the sequencer whenever an event cannot move into the output register.
module button_press_longpress_shift import bpls_pkg::*; #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [2:0]  in_button_index,
  input  logic        in_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_button,
  output logic        out_pressed,
  output logic        out_shifted,
  output logic        out_long_flag,
  output logic        out_last
);

  localparam int NB = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;
  localparam int IW = (NB > 1) ? $clog2(NB) : 1;

  ctl_cmd_t      cmd;
  dp_stat_t      stat;
  logic [IW-1:0] idx;
  event_t        out_ev;

  bpls_ctrl #(
    .NB(NB),
    .IW(IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd),
    .idx       (idx)
  );

  bpls_dp #(
    .NB(NB),
    .IW(IW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_button_index(in_button_index),
    .in_level       (in_level),
    .cmd            (cmd),
    .idx            (idx),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_ev         (out_ev),
    .out_last       (out_last)
  );

  assign out_event_button = out_ev.button;
  assign out_pressed      = out_ev.pressed;
  assign out_shifted      = out_ev.shifted;
  assign out_long_flag    = out_ev.long_flag;

endmodule

// ===== design/bpls_ctrl.sv =====
// Sequencer: accepts words, walks all buttons on a tick, orders event pushes and the final flush.
module bpls_ctrl import bpls_pkg::*; #(
  parameter int NB = 8,
  parameter int IW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_command,
  output logic          in_stall,
  input  dp_stat_t      stat,
  output ctl_cmd_t      cmd,
  output logic [IW-1:0] idx
);

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          at_end;

  assign idx    = idx_r;
  assign at_end = (idx_r == IW'(NB - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_command == CMD_TICK) begin
            state_nxt = ST_SCAN;
            idx_nxt   = '0;
          end else begin
            cmd.load_pin = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat.ev_cnt == 2'd0 || stat.push_ok) begin
          cmd.step_en = 1'b1;
          if (stat.ev_cnt == 2'd2) begin
            state_nxt = ST_SECOND;
          end else if (at_end) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_SECOND: begin
        if (stat.push_ok) begin
          cmd.push_second = 1'b1;
          if (at_end) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_SCAN;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.hold_v) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== design/bpls_dp.sv =====
// Datapath: configuration, per-button timers and levels, event hold and output registers.
module bpls_dp import bpls_pkg::*; #(
  parameter int NB = 8,
  parameter int IW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_wdata,
  input  logic [2:0]    in_button_index,
  input  logic          in_level,
  input  ctl_cmd_t      cmd,
  input  logic [IW-1:0] idx,
  output dp_stat_t      stat,
  input  logic          out_stall,
  output logic          out_valid,
  output event_t        out_ev,
  output logic          out_last
);

  logic [15:0] deb_r, long_r;
  logic [7:0]  plm_r, len_r, shv_r;
  logic [23:0] sel_r;

  logic        pin_r    [NB];
  logic        pin_nxt  [NB];
  logic        stab_r   [NB];
  logic        stab_nxt [NB];
  logic [15:0] cnt_r    [NB];
  logic [15:0] cnt_nxt  [NB];
  mode_t       mode_r   [NB];
  mode_t       mode_nxt [NB];
  logic        lpend_r  [NB];
  logic        lpend_nxt[NB];
  logic        su_r     [NB];
  logic        su_nxt   [NB];

  event_t hold_r, hold_nxt;
  logic   hold_v_r, hold_v_nxt;
  event_t out_r, out_nxt;
  logic   out_last_r, out_last_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   sec_sh_r, sec_sh_nxt;

  logic [2:0]    sel_s;
  logic          sv;
  logic [IW-1:0] si;
  logic          down, sdown, su_set;
  logic          en, is_shift, hold_mode, lp;
  logic          active, expire, start_long, was_long, quiet, shifted;
  logic [15:0]   cnt_dec;
  logic [1:0]    ev_cnt;
  event_t        ev0, new_ev;
  logic          clr_su;
  logic          push_new, out_free, push_ok;
  logic [IW-1:0] lb;
  logic          lb_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= DEBOUNCE_RESET;
      long_r <= LONG_RESET;
      plm_r  <= '0;
      len_r  <= '0;
      shv_r  <= '0;
      sel_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS:   deb_r  <= cfg_wdata[15:0];
        CFG_LONG_PRESS_TICKS: long_r <= cfg_wdata[15:0];
        CFG_PRESSED_LEVEL:    plm_r  <= cfg_wdata[7:0];
        CFG_LONG_ENABLE:      len_r  <= cfg_wdata[7:0];
        CFG_SHIFTER_VALID:    shv_r  <= cfg_wdata[7:0];
        CFG_SHIFTER_SELECT:   sel_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_s   = sel_r[3*idx +: 3];
    sv      = shv_r[idx] && ({1'b0, sel_s} < 4'(NB));
    si      = sel_s[IW-1:0];
    down    = (pin_r[idx] == plm_r[idx]);
    sdown   = (si == idx) ? down : (stab_r[si] == plm_r[si]);
    su_set  = sv && sdown;
    en      = len_r[idx];
    is_shift = 1'b0;
    for (int i = 0; i < NB; i++) begin
      if (shv_r[i] && sel_r[3*i +: 3] == 3'(idx)) begin
        is_shift = 1'b1;
      end
    end
    hold_mode  = !en && is_shift;
    lp         = en || hold_mode;
    active     = (mode_r[idx] == MODE_DEBOUNCE) || (mode_r[idx] == MODE_LONG);
    cnt_dec    = (cnt_r[idx] != 16'd0) ? cnt_r[idx] - 16'd1 : cnt_r[idx];
    expire     = active && (cnt_dec == 16'd0);
    start_long = lp && !lpend_r[idx] && down;
    was_long   = lpend_r[idx];
    quiet      = su_r[idx] || (su_set && si == idx);
    shifted    = su_set;

    ev_cnt        = 2'd0;
    ev0.button    = 3'(idx);
    ev0.pressed   = 1'b1;
    ev0.shifted   = shifted;
    ev0.long_flag = 1'b0;
    clr_su        = 1'b0;
    if (expire && !start_long) begin
      if (was_long) begin
        if (!down) begin
          ev_cnt = quiet ? 2'd0 : 2'd2;
          clr_su = 1'b1;
        end else begin
          ev_cnt        = quiet ? 2'd0 : 2'd1;
          ev0.long_flag = 1'b1;
        end
      end else begin
        ev_cnt        = quiet ? 2'd0 : 2'd1;
        ev0.pressed   = down;
        ev0.long_flag = lp;
        clr_su        = 1'b1;
      end
    end
  end

  assign lb    = in_button_index[IW-1:0];
  assign lb_ok = ({1'b0, in_button_index} < 4'(NB));

  always_comb begin
    pin_nxt   = pin_r;
    stab_nxt  = stab_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    lpend_nxt = lpend_r;
    su_nxt    = su_r;
    if (cmd.load_pin && lb_ok) begin
      pin_nxt[lb]  = in_level;
      mode_nxt[lb] = MODE_DEBOUNCE;
      cnt_nxt[lb]  = (deb_r != 16'd0) ? deb_r : 16'd1;
    end
    if (cmd.step_en && active) begin
      cnt_nxt[idx] = cnt_dec;
      if (expire) begin
        stab_nxt[idx] = pin_r[idx];
        mode_nxt[idx] = MODE_IDLE;
        if (su_set) begin
          su_nxt[si] = 1'b1;
        end
        if (start_long) begin
          lpend_nxt[idx] = 1'b1;
          if (hold_mode) begin
            mode_nxt[idx] = MODE_HOLD;
          end else begin
            mode_nxt[idx] = MODE_LONG;
            cnt_nxt[idx]  = (long_r != 16'd0) ? long_r : 16'd1;
          end
        end else begin
          lpend_nxt[idx] = 1'b0;
          if (clr_su) begin
            su_nxt[idx] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        pin_r[i]   <= 1'b0;
        stab_r[i]  <= 1'b0;
        cnt_r[i]   <= '0;
        mode_r[i]  <= MODE_IDLE;
        lpend_r[i] <= 1'b0;
        su_r[i]    <= 1'b0;
      end
    end else begin
      pin_r   <= pin_nxt;
      stab_r  <= stab_nxt;
      cnt_r   <= cnt_nxt;
      mode_r  <= mode_nxt;
      lpend_r <= lpend_nxt;
      su_r    <= su_nxt;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign push_ok  = !hold_v_r || out_free;
  assign push_new = (cmd.step_en && ev_cnt != 2'd0) || cmd.push_second;

  always_comb begin
    new_ev           = ev0;
    if (cmd.push_second) begin
      new_ev.button    = 3'(idx);
      new_ev.pressed   = 1'b0;
      new_ev.shifted   = sec_sh_r;
      new_ev.long_flag = 1'b0;
    end
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    sec_sh_nxt    = sec_sh_r;
    if (cmd.step_en && ev_cnt == 2'd2) begin
      sec_sh_nxt = shifted;
    end
    if (push_new) begin
      if (hold_v_r) begin
        out_nxt       = hold_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      hold_nxt   = new_ev;
      hold_v_nxt = 1'b1;
    end else if (cmd.flush) begin
      out_nxt       = hold_r;
      out_last_nxt  = 1'b1;
      out_valid_nxt = 1'b1;
      hold_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    sec_sh_r   <= sec_sh_nxt;
  end

  assign stat.ev_cnt   = ev_cnt;
  assign stat.push_ok  = push_ok;
  assign stat.out_free = out_free;
  assign stat.hold_v   = hold_v_r;

  assign out_valid = out_valid_r;
  assign out_ev    = out_r;
  assign out_last  = out_last_r;

endmodule
